/* hw/rtl/fac_pkg.sv */
// Shared constants, request codes and controller states for the frustum cull block.
// No dependencies; fac_sqrt, fac_div and frustum_aabb_cull_top import this package.
`timescale 1ns / 1ps

package fac_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int PLANE_COUNT = 6;
   localparam int DW          = 32;
   localparam int MAT_DEPTH   = 16;
   localparam int PL_DEPTH    = PLANE_COUNT * 4;
   localparam int MAT_AW      = $clog2(MAT_DEPTH);
   localparam int PL_AW       = $clog2(PL_DEPTH);
   localparam int RAD_W       = 2 * DW;
   localparam int ROOT_W      = DW + 1;
   localparam int SQ_STEPS    = DW;
   localparam int SQ_CW       = $clog2(SQ_STEPS);
   localparam int NUM_W       = FRAC_BITS + DW + 1;
   localparam int DIV_CW      = $clog2(NUM_W);
   localparam int ACC_W       = 64;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_BUILD = 2'd1;
   localparam logic [1:0] REQ_TEST  = 2'd2;

   localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_RD,
      ST_B_WAIT,
      ST_B_SQ,
      ST_B_SACC,
      ST_B_SQST,
      ST_B_SQRT,
      ST_B_DIVST,
      ST_B_DIV,
      ST_T_RD,
      ST_T_WAIT,
      ST_T_MUL,
      ST_T_ACC,
      ST_T_CHK,
      ST_T_OUT
   } state_type;

endpackage

/* hw/rtl/fac_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Per-entry valid bits make entries never written read back as zero after reset.
`timescale 1ns / 1ps

module fac_ram #(
   parameter int DW    = 32,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0]    mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DW-1:0]    rdata_ff;
   logic             rvld_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         if (we) begin
            vld_ff[waddr] <= 1'b1;
         end
         rvld_ff <= vld_ff[raddr];
      end
   end

   assign rdata = rvld_ff ? rdata_ff : '0;

endmodule

/* hw/rtl/fac_sqrt.sv */
// Iterative integer square root, one result bit per cycle, rounded to nearest.
// Depends on fac_pkg for widths.
`timescale 1ns / 1ps

module fac_sqrt import fac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0] s_ff, s_in;
   logic [RAD_W-1:0] r_ff, r_in;
   logic [SQ_CW-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             fin_ff, fin_in;
   logic [RAD_W-1:0] bit_val;
   logic [RAD_W:0]   trial;
   logic             ge;

   assign bit_val = {2'b01, {(RAD_W-2){1'b0}}} >> {cnt_ff, 1'b0};
   assign trial   = {1'b0, r_ff} + {1'b0, bit_val};
   assign ge      = {1'b0, s_ff} >= trial;

   always_comb begin
      s_in    = s_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (start) begin
         s_in    = radicand;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            s_in = s_ff - trial[RAD_W-1:0];
            r_in = (r_ff >> 1) + bit_val;
         end else begin
            r_in = r_ff >> 1;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CW'(SQ_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff   <= s_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
   end

   // The final remainder decides whether the root rounds up.
   assign done = fin_ff;
   assign root = r_ff[ROOT_W-1:0] + ROOT_W'(s_ff > r_ff);

endmodule

/* hw/rtl/fac_div.sv */
// Restoring divider that forms round(mag * 2^FRAC_BITS / len), one quotient bit a cycle.
// Depends on fac_pkg for widths.
`timescale 1ns / 1ps

module fac_div import fac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     mag,
   input  logic [ROOT_W-1:0] len,
   output logic              done,
   output logic [NUM_W-1:0]  quot
);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [ROOT_W:0]   rem_ff, rem_in;
   logic [ROOT_W:0]   den_ff, den_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic [ROOT_W+1:0] rem_sh;
   logic              ge;

   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   // Adding len before dividing by 2*len rounds half away from zero.
   always_comb begin
      num_in  = num_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (start) begin
         num_in  = (NUM_W'(mag) << (FRAC_BITS + 1)) + NUM_W'(len);
         den_in  = {len, 1'b0};
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (ROOT_W+1)'(rem_sh - {1'b0, den_ff}) : rem_sh[ROOT_W:0];
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         quot_in = {quot_ff[NUM_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(NUM_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
   end

   assign done = fin_ff;
   assign quot = quot_ff;

endmodule

/* hw/rtl/frustum_aabb_cull_top.sv */
// Frustum plane extraction and box culling: controller, shared multiply-accumulate
// and the matrix and plane memories. Depends on fac_pkg, fac_ram, fac_sqrt, fac_div.
//
// Usage: one request channel (req_valid/req_ready) carries three kinds of
// transaction, selected by req_type. A load writes one matrix element and is done in
// the cycle it is accepted. A build reads the matrix and writes six normalized
// planes to the plane memory, running the bit-serial square root for each plane
// and, unless the length is zero, the bit-serial divider for each component. A
// test walks the six stored planes through one shared 33x33 multiplier and then
// offers its rsp_visible result. Load and build transactions, and req_type 3, give
// no response. Requests are taken one at a time: req_ready is high only while the
// controller is idle. The response sits in an output register, so a new request is
// accepted while a result still waits; if the receiver holds rsp_ready low, the
// next test stops at its last step until the register frees. Reset clears both
// memories to zero through per-entry valid bits, with no clearing pass, and drops
// any pending response.
`timescale 1ns / 1ps

module frustum_aabb_cull_top import fac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [3:0]        req_elem_index,
   input  logic signed [31:0] req_elem_value,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic [30:0]       req_half_x,
   input  logic [30:0]       req_half_y,
   input  logic [30:0]       req_half_z,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_visible
);

   state_type state_ff, state_in;
   logic [2:0] plane_ff, plane_in;
   logic [2:0] step_ff, step_in;
   logic       rd_vld_ff, rd_vld_in;
   logic [2:0] rd_step_ff, rd_step_in;

   logic signed [DW-1:0] nv_ff [4];
   logic signed [DW-1:0] nv_in [4];
   logic signed [DW-1:0] tmp_ff, tmp_in;
   logic signed [DW-1:0] c_ff [3];
   logic signed [DW-1:0] c_in [3];
   logic [DW-2:0]        h_ff [3];
   logic [DW-2:0]        h_in [3];
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_W-1:0]     prod_ff, prod_in;
   logic                 prod_vld_ff, prod_vld_in;
   logic [ROOT_W-1:0]    len_ff, len_in;
   logic                 vis_ff, vis_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_visible_ff, rsp_visible_in;

   logic                 accept;
   logic                 mat_we;
   logic [MAT_AW-1:0]    mat_raddr;
   logic [DW-1:0]        mat_rdata;
   logic                 pl_we;
   logic [PL_AW-1:0]     pl_waddr;
   logic [DW-1:0]        pl_wdata;
   logic [PL_AW-1:0]     pl_raddr;
   logic [DW-1:0]        pl_rdata;
   logic                 mul_en;
   logic signed [DW:0]   mul_a, mul_b;
   logic signed [2*DW+1:0] mul_full;
   logic                 sq_start, sq_done;
   logic [ROOT_W-1:0]    sq_root;
   logic                 div_start, div_done;
   logic [NUM_W-1:0]     div_quot;
   logic [DW-1:0]        div_mag;
   logic                 div_neg;
   logic                 rsp_load;
   logic [1:0]           cj;
   logic signed [DW+1:0] comb_sum;
   logic signed [DW-1:0] sel_n;
   logic [DW-1:0]        sel_abs;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_T_OUT) && (!rsp_valid_ff || rsp_ready);

   fac_ram #(.DW(DW), .DEPTH(MAT_DEPTH), .AW(MAT_AW)) u_mat_ram (
      .clock (clock),
      .reset (reset),
      .we    (mat_we),
      .waddr (req_elem_index),
      .wdata (req_elem_value),
      .raddr (mat_raddr),
      .rdata (mat_rdata)
   );

   fac_ram #(.DW(DW), .DEPTH(PL_DEPTH), .AW(PL_AW)) u_plane_ram (
      .clock (clock),
      .reset (reset),
      .we    (pl_we),
      .waddr (pl_waddr),
      .wdata (pl_wdata),
      .raddr (pl_raddr),
      .rdata (pl_rdata)
   );

   fac_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   fac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .mag   (div_mag),
      .len   (len_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Next state and sequencing counters.
   always_comb begin
      state_in = state_ff;
      plane_in = plane_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            plane_in = '0;
            step_in  = '0;
            if (accept && req_type == REQ_BUILD) begin
               state_in = ST_B_RD;
            end else if (accept && req_type == REQ_TEST) begin
               state_in = ST_T_RD;
            end
         end
         ST_B_RD: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) begin
               state_in = ST_B_WAIT;
            end
         end
         ST_B_WAIT: begin
            step_in  = '0;
            state_in = ST_B_SQ;
         end
         ST_B_SQ: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd2) begin
               state_in = ST_B_SACC;
            end
         end
         ST_B_SACC: begin
            state_in = ST_B_SQST;
         end
         ST_B_SQST: begin
            state_in = ST_B_SQRT;
         end
         ST_B_SQRT: begin
            step_in = '0;
            if (sq_done) begin
               state_in = ST_B_DIVST;
            end
         end
         ST_B_DIVST, ST_B_DIV: begin
            if (state_ff == ST_B_DIVST && len_ff != '0) begin
               state_in = ST_B_DIV;
            end else if (state_ff == ST_B_DIVST || div_done) begin
               if (step_ff == 3'd3) begin
                  step_in = '0;
                  if (plane_ff == 3'(PLANE_COUNT - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     plane_in = plane_ff + 1'b1;
                     state_in = ST_B_RD;
                  end
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_B_DIVST;
               end
            end
         end
         ST_T_RD: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd3) begin
               state_in = ST_T_WAIT;
            end
         end
         ST_T_WAIT: begin
            step_in  = '0;
            state_in = ST_T_MUL;
         end
         ST_T_MUL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd5) begin
               state_in = ST_T_ACC;
            end
         end
         ST_T_ACC: begin
            state_in = ST_T_CHK;
         end
         ST_T_CHK: begin
            step_in = '0;
            if (plane_ff == 3'(PLANE_COUNT - 1)) begin
               state_in = ST_T_OUT;
            end else begin
               plane_in = plane_ff + 1'b1;
               state_in = ST_T_RD;
            end
         end
         ST_T_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control outputs: memory ports, unit starts and multiplier operands.
   always_comb begin
      mat_we    = accept && (req_type == REQ_LOAD);
      mat_raddr = {step_ff[2:1], (step_ff[0] ? plane_ff[2:1] : 2'd3)};
      pl_raddr  = PL_AW'({plane_ff, step_ff[1:0]});
      pl_waddr  = PL_AW'({plane_ff, step_ff[1:0]});
      pl_we     = 1'b0;
      pl_wdata  = '0;
      sq_start  = 1'b0;
      div_start = 1'b0;
      mul_en    = 1'b0;
      cj        = step_ff[2:1];
      sel_n     = nv_ff[step_ff[1:0]];
      sel_abs   = sel_n[DW-1] ? DW'(-sel_n) : DW'(sel_n);
      div_neg   = sel_n[DW-1];
      div_mag   = sel_abs;
      mul_a     = (DW+1)'(sel_n);
      mul_b     = (DW+1)'(sel_n);
      case (state_ff)
         ST_B_SQ: begin
            mul_en = 1'b1;
         end
         ST_B_SQST: begin
            sq_start = 1'b1;
         end
         ST_B_DIVST: begin
            if (len_ff == '0) begin
               pl_we = 1'b1;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_B_DIV: begin
            if (div_done) begin
               pl_we = 1'b1;
               if (div_neg) begin
                  pl_wdata = (|div_quot[NUM_W-1:DW-1]) ? SAT_MIN : DW'(-div_quot[DW-1:0]);
               end else begin
                  pl_wdata = (|div_quot[NUM_W-1:DW-1]) ? SAT_MAX : div_quot[DW-1:0];
               end
            end
         end
         ST_T_MUL: begin
            mul_en  = 1'b1;
            sel_n   = nv_ff[cj];
            sel_abs = sel_n[DW-1] ? DW'(-sel_n) : DW'(sel_n);
            if (step_ff[0]) begin
               mul_a = signed'({1'b0, sel_abs});
               mul_b = signed'({2'b00, h_ff[cj]});
            end else begin
               mul_a = (DW+1)'(sel_n);
               mul_b = (DW+1)'(c_ff[cj]);
            end
         end
         default: begin
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // Datapath registers.
   always_comb begin
      nv_in        = nv_ff;
      tmp_in       = tmp_ff;
      c_in         = c_ff;
      h_in         = h_ff;
      len_in       = len_ff;
      vis_in       = vis_ff;
      rd_vld_in    = (state_ff == ST_B_RD) || (state_ff == ST_T_RD);
      rd_step_in   = step_ff;
      prod_vld_in  = mul_en;
      prod_in      = mul_full[ACC_W-1:0];
      acc_in       = prod_vld_ff ? acc_ff + prod_ff : acc_ff;
      comb_sum     = '0;
      rsp_visible_in = rsp_visible_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
      if (rsp_load) begin
         rsp_visible_in = vis_ff;
      end
      if (accept && req_type == REQ_TEST) begin
         c_in[0] = req_center_x;
         c_in[1] = req_center_y;
         c_in[2] = req_center_z;
         h_in[0] = req_half_x;
         h_in[1] = req_half_y;
         h_in[2] = req_half_z;
         vis_in  = 1'b1;
      end
      // Matrix reads: the column-four term first (zero for plane 4), then column plane/2 with the plane's sign.
      if (rd_vld_ff && (state_ff == ST_B_RD || state_ff == ST_B_WAIT)) begin
         if (!rd_step_ff[0]) begin
            tmp_in = (plane_ff == 3'd4) ? '0 : signed'(mat_rdata);
         end else begin
            if (plane_ff[0]) begin
               comb_sum = (DW+2)'(tmp_ff) - (DW+2)'(signed'(mat_rdata));
            end else begin
               comb_sum = (DW+2)'(tmp_ff) + (DW+2)'(signed'(mat_rdata));
            end
            if (comb_sum > (DW+2)'(signed'(SAT_MAX))) begin
               nv_in[rd_step_ff[2:1]] = signed'(SAT_MAX);
            end else if (comb_sum < (DW+2)'(signed'(SAT_MIN))) begin
               nv_in[rd_step_ff[2:1]] = signed'(SAT_MIN);
            end else begin
               nv_in[rd_step_ff[2:1]] = comb_sum[DW-1:0];
            end
         end
      end
      if (rd_vld_ff && (state_ff == ST_T_RD || state_ff == ST_T_WAIT)) begin
         nv_in[rd_step_ff[1:0]] = signed'(pl_rdata);
      end
      if (state_ff == ST_B_SQ && step_ff == '0) begin
         acc_in = '0;
      end
      if (state_ff == ST_T_MUL && step_ff == '0) begin
         acc_in = ACC_W'(nv_ff[3]) <<< FRAC_BITS;
      end
      if (state_ff == ST_B_SQRT && sq_done) begin
         len_in = sq_root;
      end
      if (state_ff == ST_T_CHK) begin
         vis_in = vis_ff && !acc_ff[ACC_W-1];
      end
   end

   always_ff @(posedge clock) begin
      nv_ff          <= nv_in;
      tmp_ff         <= tmp_in;
      c_ff           <= c_in;
      h_ff           <= h_in;
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      len_ff         <= len_in;
      vis_ff         <= vis_in;
      rd_step_ff     <= rd_step_in;
      rsp_visible_ff <= rsp_visible_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plane_ff     <= '0;
         step_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plane_ff     <= plane_in;
         step_ff      <= step_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for frustum_aabb_cull_top: matrix loads, plane builds and box tests.
// Depends on fac_pkg for request codes; predicts visibility with its own fixed-point model.
`timescale 1ns / 1ps

module tb import fac_pkg::*; ();

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         idx;
      logic signed [31:0] val;
      logic signed [31:0] cx, cy, cz;
      logic [30:0]        hx, hy, hz;
      logic               hold;
   } cull_req_type;

   // The one request code that the block ignores.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = REQ_LOAD;
   logic [3:0] req_elem_index = '0;
   logic signed [31:0] req_elem_value = '0;
   logic signed [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [30:0] req_half_x = '0, req_half_y = '0, req_half_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_visible;

   cull_req_type pending_reqs[$];
   logic       visible_expected[$];
   logic signed [63:0] mat_copy[16] = '{default: '0};
   logic signed [63:0] plane_copy[24] = '{default: '0};
   int         fail_count = 0;
   int         tests_seen = 0;
   int         builds_sent = 0;
   int         idle_cycles = 0;
   int         send_wait = 0;
   int         recv_wait = 0;
   bit         stimulus_done = 0;

   always #2 clock = ~clock;

   frustum_aabb_cull_top i_dut (.*);

   function automatic logic signed [63:0] sat_to_32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] root_nearest(logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (s > r) r = r + 1;
      return r;
   endfunction

   function automatic logic signed [63:0] scale_by_len(logic signed [63:0] v, logic [63:0] len);
      logic [63:0] mag, q;
      mag = (v < 0) ? -v : v;
      q = ((mag << (FRAC_BITS + 1)) + len) / (len << 1);
      if (v < 0) return (q >= 64'h8000_0000) ? -64'sd2147483648 : -$signed(q);
      return (q > 64'h7FFF_FFFF) ? 64'sd2147483647 : $signed(q);
   endfunction

   task automatic extract_planes();
      logic signed [63:0] v[4];
      logic [63:0] s, len;
      int k, sgn;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         k = p / 2;
         sgn = (p % 2) ? -1 : 1;
         s = 0;
         for (int j = 0; j < 4; j++) begin
            v[j] = (p == 4) ? 64'sd0 : mat_copy[j*4+3];
            v[j] = sat_to_32(v[j] + sgn * mat_copy[j*4+k]);
         end
         for (int j = 0; j < 3; j++) s = s + 64'(v[j] * v[j]);
         len = root_nearest(s);
         for (int j = 0; j < 4; j++)
            plane_copy[p*4+j] = (len == 0) ? 64'sd0 : scale_by_len(v[j], len);
      end
   endtask

   function automatic logic box_visible(cull_req_type r);
      logic [63:0] acc;
      logic signed [63:0] n, c[3];
      logic [63:0] h[3];
      c[0] = r.cx; c[1] = r.cy; c[2] = r.cz;
      h[0] = r.hx; h[1] = r.hy; h[2] = r.hz;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         acc = 64'(plane_copy[p*4+3]) << FRAC_BITS;
         for (int j = 0; j < 3; j++) begin
            n = plane_copy[p*4+j];
            acc = acc + 64'(n * c[j]) + h[j] * ((n < 0) ? -n : n);
         end
         if (acc[63]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic cull_req_type rand_box();
      cull_req_type r;
      int mode;
      r = '0;
      r.kind = REQ_TEST;
      mode = $urandom_range(0, 3);
      r.cx = $urandom; r.cy = $urandom; r.cz = $urandom;
      r.hx = 31'($urandom); r.hy = 31'($urandom); r.hz = 31'($urandom);
      if (mode != 0) begin
         // Keep most boxes near unit scale so that culling goes both ways.
         r.cx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         r.cy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         r.cz = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         r.hx = 31'($urandom_range(0, 32'h0001_0000));
         r.hy = 31'($urandom_range(0, 32'h0001_0000));
         r.hz = 31'($urandom_range(0, 32'h0001_0000));
      end
      return r;
   endfunction

   function automatic cull_req_type mk_load(int idx, logic [31:0] val);
      cull_req_type r;
      r = '0;
      r.kind = REQ_LOAD;
      r.idx = 4'(idx);
      r.val = val;
      r.cx = $urandom;
      return r;
   endfunction

   initial begin
      cull_req_type r;
      logic [31:0] m[16];
      // Directed: boxes against an all-zero plane set, extreme fields, a zero-normal build.
      r = '0; r.kind = REQ_TEST; r.cx = 32'h8000_0000; r.hx = '1;
      pending_reqs.push_back(r);
      r.kind = REQ_UNUSED; pending_reqs.push_back(r);
      pending_reqs.push_back('{kind: REQ_BUILD, default: '0});
      r.kind = REQ_TEST; r.cx = 32'h7FFF_FFFF; r.cy = 32'h8000_0000; r.hy = '1;
      pending_reqs.push_back(r);
      pending_reqs.push_back(mk_load(15, 32'h0001_0000));
      pending_reqs.push_back(mk_load(0, 32'h7FFF_FFFF));
      pending_reqs.push_back(mk_load(3, 32'h7FFF_FFFF));
      pending_reqs.push_back(mk_load(5, 32'h8000_0000));
      pending_reqs.push_back(mk_load(7, 32'h8000_0000));
      pending_reqs.push_back(mk_load(10, 32'h0001_0000));
      pending_reqs.push_back('{kind: REQ_BUILD, default: '0});
      r = '0; r.kind = REQ_TEST; pending_reqs.push_back(r);
      r.cx = 32'h8000_0000; r.cy = 32'h7FFF_FFFF; r.cz = 32'h8000_0000; r.hz = '1;
      pending_reqs.push_back(r);
      r.hold = 1'b1; r.cx = 32'h0010_0000; r.hx = '0; r.hz = '0;
      pending_reqs.push_back(r);
      for (int g = 0; g < 60; g++) begin
         // Mostly a sane perspective-like matrix with noise, sometimes fully random.
         for (int i = 0; i < 16; i++) begin
            m[i] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            if ($urandom_range(0, 9) == 0) m[i] = $urandom;
         end
         if ($urandom_range(0, 3) != 0) begin
            m[0] = 32'h0001_0000 + $urandom_range(0, 32'h8000);
            m[5] = 32'h0001_0000 + $urandom_range(0, 32'h8000);
            m[11] = 32'h0001_0000;
            m[15] = 0;
         end
         for (int i = 0; i < 16; i++)
            if ($urandom_range(0, 7) != 0) pending_reqs.push_back(mk_load(i, m[i]));
         if ($urandom_range(0, 9) == 0) pending_reqs.push_back(r);
         r = '0; r.kind = REQ_BUILD; r.cx = $urandom;
         pending_reqs.push_back(r);
         for (int t = 0; t < 15; t++) begin
            r = rand_box();
            if ($urandom_range(0, 30) == 0) r.kind = REQ_UNUSED;
            pending_reqs.push_back(r);
         end
      end
   end

   task automatic r_drive(cull_req_type r);
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_elem_index <= r.idx;
      req_elem_value <= r.val;
      req_center_x <= r.cx;
      req_center_y <= r.cy;
      req_center_z <= r.cz;
      req_half_x <= r.hx;
      req_half_y <= r.hy;
      req_half_z <= r.hz;
   endtask

   // Driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         if (req_type == REQ_LOAD) mat_copy[req_elem_index] <= req_elem_value;
         else if (req_type == REQ_BUILD) extract_planes();
         else if (req_type == REQ_TEST) begin
            visible_expected.push_back(box_visible('{kind: req_type, idx: req_elem_index,
               val: req_elem_value, cx: req_center_x, cy: req_center_y, cz: req_center_z,
               hx: req_half_x, hy: req_half_y, hz: req_half_z, hold: 1'b0}));
            tests_seen <= tests_seen + 1;
         end
         if (req_type == REQ_BUILD) builds_sent <= builds_sent + 1;
         req_valid <= 1'b0;
         send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      end else if (!req_valid) begin
         if (send_wait > 0) begin
            send_wait <= send_wait - 1;
         end else if (pending_reqs.size() == 0) begin
            stimulus_done <= 1;
         end else if (!(pending_reqs[0].hold && visible_expected.size() != 0)) begin
            r_drive(pending_reqs.pop_front());
         end
      end
   end

   // Monitor and response-side stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (visible_expected.size() == 0) begin
               $error("unexpected response transaction, visible=%0b", rsp_visible);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_visible !== visible_expected[0]) begin
                  $error("visible mismatch: expected %0b actual %0b",
                         visible_expected[0], rsp_visible);
                  fail_count <= fail_count + 1;
               end
               void'(visible_expected.pop_front());
            end
            recv_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: fails the run when neither a request nor a response is taken within the limit below.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("frustum_aabb_cull_top test failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && visible_expected.size() == 0);
      repeat (200) @(posedge clock);
      $display("Ran %0d box tests across %0d plane builds with random stalls on both sides.",
               tests_seen, builds_sent);
      if (fail_count == 0 && visible_expected.size() == 0)
         $display("frustum_aabb_cull_top test passed");
      else
         $display("frustum_aabb_cull_top test failed");
      $finish;
   end
endmodule
